// File: rtl/core/stun_binding_response_parser_assert.svh
// Assertion macros used by the top-level parser file.
`ifndef STUN_BINDING_RESPONSE_PARSER_ASSERT_SVH
`define STUN_BINDING_RESPONSE_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SBRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sbrp_pkg.sv
`timescale 1ns / 1ps

package sbrp_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65535;

  localparam logic [16:0] HEADER_BYTES = 17'd20;
  localparam logic [16:0] OFFSET_MAX   = 17'h1FFFF;
  localparam logic [31:0] COOKIE_VAL   = 32'h2112A442;
  localparam logic [15:0] TYPE_RESP    = 16'h0101;
  localparam logic [15:0] TYPE_ERR     = 16'h0111;
  localparam logic [15:0] ATTR_XOR_MAP = 16'h0020;
  localparam logic [15:0] ATTR_MAP     = 16'h0001;
  localparam logic [7:0]  FAMILY_IPV4  = 8'h01;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_ERROR  = 2'd1;
  localparam logic [1:0] ST_FOUND  = 2'd2;
  localparam logic [1:0] ST_NOADDR = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_XOR  = 2'd1;
  localparam logic [1:0] KIND_MAP  = 2'd2;

  localparam int unsigned TDATA_BITS = 152;

  // Header view: current offset and length, plus field values after this byte.
  typedef struct packed {
    logic [16:0] pos;
    logic [15:0] decl_len;
    logic [15:0] msg_type;
    logic [31:0] cookie;
    logic [31:0] txn_hi;
    logic [63:0] txn_lo;
  } hdr_info_t;

  // Walker view after this byte.
  typedef struct packed {
    logic [1:0]  found;
    logic [15:0] port;
    logic [31:0] addr;
  } walk_info_t;

endpackage

// File: rtl/core/sbrp_hdr.sv
`timescale 1ns / 1ps

module sbrp_hdr (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                last,
  input  logic [7:0]          data_byte,
  output sbrp_pkg::hdr_info_t info
);

  logic [16:0] pos_r, pos_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [31:0] cookie_r, cookie_nxt;
  logic [31:0] txn_hi_r, txn_hi_nxt;
  logic [63:0] txn_lo_r, txn_lo_nxt;

  always_comb begin
    type_nxt   = type_r;
    dlen_nxt   = dlen_r;
    cookie_nxt = cookie_r;
    txn_hi_nxt = txn_hi_r;
    txn_lo_nxt = txn_lo_r;
    if (pos_r < 17'd2) begin
      type_nxt = {type_r[7:0], data_byte};
    end else if (pos_r < 17'd4) begin
      dlen_nxt = {dlen_r[7:0], data_byte};
    end else if (pos_r < 17'd8) begin
      cookie_nxt = {cookie_r[23:0], data_byte};
    end else if (pos_r < 17'd12) begin
      txn_hi_nxt = {txn_hi_r[23:0], data_byte};
    end else if (pos_r < sbrp_pkg::HEADER_BYTES) begin
      txn_lo_nxt = {txn_lo_r[55:0], data_byte};
    end
    pos_nxt = (pos_r < sbrp_pkg::OFFSET_MAX) ? pos_r + 17'd1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      type_r   <= '0;
      dlen_r   <= '0;
      cookie_r <= '0;
      txn_hi_r <= '0;
      txn_lo_r <= '0;
    end else if (step) begin
      if (last) begin
        pos_r    <= '0;
        type_r   <= '0;
        dlen_r   <= '0;
        cookie_r <= '0;
        txn_hi_r <= '0;
        txn_lo_r <= '0;
      end else begin
        pos_r    <= pos_nxt;
        type_r   <= type_nxt;
        dlen_r   <= dlen_nxt;
        cookie_r <= cookie_nxt;
        txn_hi_r <= txn_hi_nxt;
        txn_lo_r <= txn_lo_nxt;
      end
    end
  end

  assign info.pos      = pos_r;
  assign info.decl_len = dlen_r;
  assign info.msg_type = type_nxt;
  assign info.cookie   = cookie_nxt;
  assign info.txn_hi   = txn_hi_nxt;
  assign info.txn_lo   = txn_lo_nxt;

endmodule

// File: rtl/core/sbrp_walk.sv
`timescale 1ns / 1ps

module sbrp_walk (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 last,
  input  logic [7:0]           data_byte,
  input  logic [16:0]          pos,
  input  logic [15:0]          decl_len,
  output sbrp_pkg::walk_info_t info
);

  logic [16:0] start_r, start_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  family_r, family_nxt;
  logic [15:0] port_r, port_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [1:0]  found_r, found_nxt;
  logic        stop_r, stop_nxt;

  logic [16:0] end_pos;
  logic [16:0] rel;
  logic [16:0] vi;
  logic [17:0] attr_end;
  logic [17:0] padded_next;
  logic        active;

  always_comb begin
    start_nxt  = start_r;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    family_nxt = family_r;
    port_nxt   = port_r;
    addr_nxt   = addr_r;
    found_nxt  = found_r;
    stop_nxt   = stop_r;

    end_pos     = sbrp_pkg::HEADER_BYTES + {1'b0, decl_len};
    rel         = pos - start_r;
    vi          = rel - 17'd4;
    attr_end    = {1'b0, start_r} + 18'd4 + {2'b00, len_r | {8'h00, data_byte}};
    padded_next = {1'b0, start_r} + 18'd4 + ((18'({2'b00, len_r}) + 18'd3) & ~18'd3);
    active      = (pos < 17'(sbrp_pkg::MAX_PACKET_BYTES)) && !stop_r &&
                  (found_r == sbrp_pkg::KIND_NONE) && (pos >= start_r) && (pos < end_pos);

    if (active) begin
      if (rel == 17'd0) begin
        kind_nxt = {data_byte, 8'h00};
      end else if (rel == 17'd1) begin
        kind_nxt = kind_r | {8'h00, data_byte};
      end else if (rel == 17'd2) begin
        len_nxt = {data_byte, 8'h00};
      end else if (rel == 17'd3) begin
        len_nxt = len_r | {8'h00, data_byte};
        if (attr_end > {1'b0, end_pos}) begin
          stop_nxt = 1'b1;
        end else if (len_nxt == 16'd0) begin
          start_nxt = start_r + 17'd4;
        end
      end else begin
        if (vi == 17'd1) begin
          family_nxt = data_byte;
        end else if (vi == 17'd2 || vi == 17'd3) begin
          port_nxt = {port_r[7:0], data_byte};
        end else if (vi >= 17'd4 && vi <= 17'd7) begin
          addr_nxt = {addr_r[23:0], data_byte};
        end
        if (vi + 17'd1 == {1'b0, len_r}) begin
          if (len_r >= 16'd8 && family_nxt == sbrp_pkg::FAMILY_IPV4) begin
            if (kind_r == sbrp_pkg::ATTR_XOR_MAP) begin
              port_nxt  = port_nxt ^ sbrp_pkg::COOKIE_VAL[31:16];
              addr_nxt  = addr_nxt ^ sbrp_pkg::COOKIE_VAL;
              found_nxt = sbrp_pkg::KIND_XOR;
            end else if (kind_r == sbrp_pkg::ATTR_MAP) begin
              found_nxt = sbrp_pkg::KIND_MAP;
            end
          end
          start_nxt = padded_next[16:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= sbrp_pkg::HEADER_BYTES;
      kind_r   <= '0;
      len_r    <= '0;
      family_r <= '0;
      port_r   <= '0;
      addr_r   <= '0;
      found_r  <= sbrp_pkg::KIND_NONE;
      stop_r   <= 1'b0;
    end else if (step) begin
      if (last) begin
        start_r  <= sbrp_pkg::HEADER_BYTES;
        kind_r   <= '0;
        len_r    <= '0;
        family_r <= '0;
        port_r   <= '0;
        addr_r   <= '0;
        found_r  <= sbrp_pkg::KIND_NONE;
        stop_r   <= 1'b0;
      end else begin
        start_r  <= start_nxt;
        kind_r   <= kind_nxt;
        len_r    <= len_nxt;
        family_r <= family_nxt;
        port_r   <= port_nxt;
        addr_r   <= addr_nxt;
        found_r  <= found_nxt;
        stop_r   <= stop_nxt;
      end
    end
  end

  assign info.found = found_nxt;
  assign info.port  = port_nxt;
  assign info.addr  = addr_nxt;

endmodule

// File: rtl/core/stun_binding_response_parser.sv
`timescale 1ns / 1ps
`include "stun_binding_response_parser_assert.svh"

// Parses a STUN Binding Response one UDP payload byte per item and delivers one
// result item per packet, on the byte marked tlast. Bytes are taken at one per
// cycle when not stalled: each byte lands in an input register and updates the header
// and attribute parsers when it advances, and on a last byte the result is loaded into
// the output register at that same edge, from which it is offered on out_tdata.
// The input side stalls only when a last byte is waiting and the previous result
// has not yet been taken. After each last byte the parser is back in its reset state.

module stun_binding_response_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // txn_id_high, txn_id_low, mapped_ipv4, mapped_port, address_kind, zero pad
  output logic [sbrp_pkg::TDATA_BITS-1:0] out_tdata,
  output logic [1:0]   out_tuser   // status
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       advance;

  logic                          out_vld_r;
  logic [sbrp_pkg::TDATA_BITS-1:0] out_data_r, out_data_nxt;
  logic [1:0]                    out_user_r, out_user_nxt;

  sbrp_pkg::hdr_info_t  hdr;
  sbrp_pkg::walk_info_t walk;

  logic is_reply;

  assign advance   = in_vld_r && (!in_last_r || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  sbrp_hdr u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .last      (in_last_r),
    .data_byte (in_byte_r),
    .info      (hdr)
  );

  sbrp_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .last      (in_last_r),
    .data_byte (in_byte_r),
    .pos       (hdr.pos),
    .decl_len  (hdr.decl_len),
    .info      (walk)
  );

  always_comb begin
    is_reply = (hdr.pos >= (sbrp_pkg::HEADER_BYTES - 17'd1)) &&
               (hdr.cookie == sbrp_pkg::COOKIE_VAL) &&
               (hdr.msg_type == sbrp_pkg::TYPE_RESP || hdr.msg_type == sbrp_pkg::TYPE_ERR);
    out_data_nxt = '0;
    out_user_nxt = sbrp_pkg::ST_NONE;
    if (is_reply) begin
      out_data_nxt[31:0]  = hdr.txn_hi;
      out_data_nxt[95:32] = hdr.txn_lo;
      if (hdr.msg_type == sbrp_pkg::TYPE_ERR) begin
        out_user_nxt = sbrp_pkg::ST_ERROR;
      end else if (walk.found != sbrp_pkg::KIND_NONE) begin
        out_user_nxt          = sbrp_pkg::ST_FOUND;
        out_data_nxt[127:96]  = walk.addr;
        out_data_nxt[143:128] = walk.port;
        out_data_nxt[145:144] = walk.found;
      end else begin
        out_user_nxt = sbrp_pkg::ST_NOADDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `SBRP_ASSERT_NOW(a_stall_cause, !in_tready, in_vld_r && in_last_r && out_vld_r && !out_tready, "input stalled without a waiting result")
  `SBRP_ASSERT_NOW(a_none_is_zero, out_tvalid && out_tuser == sbrp_pkg::ST_NONE, out_tdata == '0, "non-STUN result carries data")
  `SBRP_ASSERT_NOW(a_kind_matches, out_tvalid, (out_tuser == sbrp_pkg::ST_FOUND) == (out_tdata[145:144] != sbrp_pkg::KIND_NONE), "address kind disagrees with status")
  `SBRP_ASSERT_NEXT(a_offset_clear, advance && in_last_r, hdr.pos == 17'd0, "offset not cleared after last byte")

endmodule

// File: verif/tb_stun_binding_response_parser.sv
`timescale 1ns / 1ps

module tb_stun_binding_response_parser;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_BYTES   = 1220;
  localparam int RANDOM_PACKETS = 28;
  localparam int IDLE_PERCENT   = 23;

  localparam logic [15:0] TYPE_REQUEST = 16'h0001;
  localparam logic [15:0] ATTR_OTHER   = 16'h8028;
  localparam logic [7:0]  FAMILY_IPV6  = 8'h02;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] txn_hi;
    logic [63:0] txn_lo;
    logic [31:0] ipv4;
    logic [15:0] port;
    logic [1:0]  kind;
  } reply_t;

  typedef enum {
    SH_SINGLE, SH_NINETEEN, SH_BAD_COOKIE, SH_BAD_TYPE, SH_HDR_ONLY, SH_ERROR,
    SH_XOR_ONES, SH_MAP_ZEROS, SH_SKIP_IPV6, SH_SKIP_SHORT, SH_ZERO_LEN, SH_ODD_PAD,
    SH_TWO_ADDR, SH_DECL_SHORT, SH_DECL_LONG, SH_CUT_VALUE
  } shape_t;

  typedef struct {
    shape_t shape;
    bit     typed;
    reply_t want;
  } row_t;

  localparam reply_t NOT_STUN       = '0;
  localparam reply_t HDR_ONLY_REPLY = {sbrp_pkg::ST_NOADDR, 146'd0};

  row_t plan [16] = '{
    '{SH_SINGLE,     1'b1, NOT_STUN},
    '{SH_NINETEEN,   1'b1, NOT_STUN},
    '{SH_BAD_COOKIE, 1'b1, NOT_STUN},
    '{SH_BAD_TYPE,   1'b1, NOT_STUN},
    '{SH_HDR_ONLY,   1'b1, HDR_ONLY_REPLY},
    '{SH_ERROR,      1'b0, NOT_STUN},
    '{SH_XOR_ONES,   1'b0, NOT_STUN},
    '{SH_MAP_ZEROS,  1'b0, NOT_STUN},
    '{SH_SKIP_IPV6,  1'b0, NOT_STUN},
    '{SH_SKIP_SHORT, 1'b0, NOT_STUN},
    '{SH_ZERO_LEN,   1'b0, NOT_STUN},
    '{SH_ODD_PAD,    1'b0, NOT_STUN},
    '{SH_TWO_ADDR,   1'b0, NOT_STUN},
    '{SH_DECL_SHORT, 1'b0, NOT_STUN},
    '{SH_DECL_LONG,  1'b0, NOT_STUN},
    '{SH_CUT_VALUE,  1'b0, NOT_STUN}
  };

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic [1:0]   out_tuser;

  stun_binding_response_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parser state mirrored from the block.
  logic [16:0] pkt_pos;
  logic [15:0] hdr_type;
  logic [15:0] hdr_len;
  logic [31:0] hdr_cookie;
  logic [31:0] txn_hi;
  logic [63:0] txn_lo;
  logic [16:0] tlv_base;
  logic [15:0] tlv_type;
  logic [15:0] tlv_len;
  logic [7:0]  tlv_family;
  logic [15:0] tlv_port;
  logic [31:0] tlv_addr;
  logic [1:0]  addr_src;
  logic        tlv_halt;

  reply_t     replies_due [$];
  logic [7:0] pkt [$];
  reply_t     typed_reply;
  bit         use_typed   = 1'b0;
  int         idle_pct    = IDLE_PERCENT;
  int         errors      = 0;
  int         bytes_sent  = 0;
  int         quiet_cycles = 0;

  task automatic clear_parse_state();
    pkt_pos    = '0;
    hdr_type   = '0;
    hdr_len    = '0;
    hdr_cookie = '0;
    txn_hi     = '0;
    txn_lo     = '0;
    tlv_base   = sbrp_pkg::HEADER_BYTES;
    tlv_type   = '0;
    tlv_len    = '0;
    tlv_family = '0;
    tlv_port   = '0;
    tlv_addr   = '0;
    addr_src   = sbrp_pkg::KIND_NONE;
    tlv_halt   = 1'b0;
  endtask

  task automatic walk_tlv(input logic [7:0] b, input int unsigned pos);
    int unsigned stop_at;
    int unsigned rel;
    int unsigned vi;
    stop_at = sbrp_pkg::HEADER_BYTES + hdr_len;
    if (tlv_halt || addr_src != sbrp_pkg::KIND_NONE || pos < tlv_base || pos >= stop_at)
      return;
    rel = pos - tlv_base;
    case (rel)
      0: tlv_type = {b, 8'h00};
      1: tlv_type = tlv_type | {8'h00, b};
      2: tlv_len = {b, 8'h00};
      3: begin
        tlv_len = tlv_len | {8'h00, b};
        if (int'(tlv_base) + 4 + int'(tlv_len) > stop_at) begin
          tlv_halt = 1'b1;
        end else if (tlv_len == 16'd0) begin
          tlv_base = tlv_base + 17'd4;
        end
      end
      default: begin
        vi = rel - 4;
        if (vi == 1) tlv_family = b;
        else if (vi == 2 || vi == 3) tlv_port = {tlv_port[7:0], b};
        else if (vi >= 4 && vi <= 7) tlv_addr = {tlv_addr[23:0], b};
        if (vi + 1 == tlv_len) begin
          if (tlv_len >= 16'd8 && tlv_family == sbrp_pkg::FAMILY_IPV4) begin
            if (tlv_type == sbrp_pkg::ATTR_XOR_MAP) begin
              tlv_port = tlv_port ^ sbrp_pkg::COOKIE_VAL[31:16];
              tlv_addr = tlv_addr ^ sbrp_pkg::COOKIE_VAL;
              addr_src = sbrp_pkg::KIND_XOR;
            end else if (tlv_type == sbrp_pkg::ATTR_MAP) begin
              addr_src = sbrp_pkg::KIND_MAP;
            end
          end
          tlv_base = 17'(int'(tlv_base) + 4 + ((int'(tlv_len) + 3) & ~3));
        end
      end
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit emitted, output reply_t r);
    int unsigned pos;
    pos = pkt_pos;
    emitted = 1'b0;
    r = '0;
    if (pos < sbrp_pkg::MAX_PACKET_BYTES) begin
      if (pos < 2) hdr_type = {hdr_type[7:0], b};
      else if (pos < 4) hdr_len = {hdr_len[7:0], b};
      else if (pos < 8) hdr_cookie = {hdr_cookie[23:0], b};
      else if (pos < 12) txn_hi = {txn_hi[23:0], b};
      else if (pos < sbrp_pkg::HEADER_BYTES) txn_lo = {txn_lo[55:0], b};
      else walk_tlv(b, pos);
    end
    if (pkt_pos != sbrp_pkg::OFFSET_MAX) pkt_pos = pkt_pos + 17'd1;
    if (last) begin
      emitted = 1'b1;
      if (pos + 1 >= sbrp_pkg::HEADER_BYTES && hdr_cookie == sbrp_pkg::COOKIE_VAL &&
          (hdr_type == sbrp_pkg::TYPE_RESP || hdr_type == sbrp_pkg::TYPE_ERR)) begin
        r.txn_hi = txn_hi;
        r.txn_lo = txn_lo;
        if (hdr_type == sbrp_pkg::TYPE_ERR) begin
          r.status = sbrp_pkg::ST_ERROR;
        end else if (addr_src != sbrp_pkg::KIND_NONE) begin
          r.status = sbrp_pkg::ST_FOUND;
          r.ipv4   = tlv_addr;
          r.port   = tlv_port;
          r.kind   = addr_src;
        end else begin
          r.status = sbrp_pkg::ST_NOADDR;
        end
      end
      clear_parse_state();
    end
  endtask

  function automatic logic [31:0] edgy_word();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    pkt.insert(pkt.size(), b);
  endtask

  task automatic start_hdr(input logic [15:0] mtype, input logic [31:0] cookie,
                           input logic [31:0] thi, input logic [63:0] tlo);
    int i;
    pkt.delete();
    add_byte(mtype[15:8]);
    add_byte(mtype[7:0]);
    add_byte(8'h00);
    add_byte(8'h00);
    for (i = 0; i < 4; i++) add_byte(8'(cookie >> (24 - 8 * i)));
    for (i = 0; i < 4; i++) add_byte(8'(thi >> (24 - 8 * i)));
    for (i = 0; i < 8; i++) add_byte(8'(tlo >> (56 - 8 * i)));
  endtask

  task automatic add_attr(input logic [15:0] kind, input int unsigned len,
                          input logic [7:0] fam, input logic [15:0] port,
                          input logic [31:0] addr);
    int unsigned i;
    logic [7:0] v;
    add_byte(kind[15:8]);
    add_byte(kind[7:0]);
    add_byte(8'(len >> 8));
    add_byte(8'(len));
    for (i = 0; i < ((len + 3) & ~3); i++) begin
      case (i)
        1: v = fam;
        2: v = port[15:8];
        3: v = port[7:0];
        4: v = addr[31:24];
        5: v = addr[23:16];
        6: v = addr[15:8];
        7: v = addr[7:0];
        default: v = 8'($urandom);
      endcase
      add_byte(v);
    end
  endtask

  task automatic set_len(input int unsigned n);
    pkt[2] = 8'(n >> 8);
    pkt[3] = 8'(n);
  endtask

  task automatic fit_len();
    set_len(pkt.size() - sbrp_pkg::HEADER_BYTES);
  endtask

  task automatic build_shape(input shape_t s);
    case (s)
      SH_SINGLE: begin
        pkt.delete();
        add_byte(8'hFF);
      end
      SH_NINETEEN: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, '1, '1);
        pkt.delete(pkt.size() - 1);
      end
      SH_BAD_COOKIE: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL ^ 32'h1, $urandom,
                  {$urandom, $urandom});
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        fit_len();
      end
      SH_BAD_TYPE: begin
        start_hdr(TYPE_REQUEST, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        fit_len();
      end
      SH_HDR_ONLY: start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, '0, '0);
      SH_ERROR: begin
        start_hdr(sbrp_pkg::TYPE_ERR, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        fit_len();
      end
      SH_XOR_ONES: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, '1, '1);
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 8, sbrp_pkg::FAMILY_IPV4, '1, '1);
        fit_len();
      end
      SH_MAP_ZEROS: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, '0, '0);
        add_attr(sbrp_pkg::ATTR_MAP, 8, sbrp_pkg::FAMILY_IPV4, '0, '0);
        fit_len();
      end
      SH_SKIP_IPV6: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 20, FAMILY_IPV6, $urandom, $urandom);
        add_attr(sbrp_pkg::ATTR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        fit_len();
      end
      SH_SKIP_SHORT: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 4, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        add_attr(ATTR_OTHER, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        fit_len();
      end
      SH_ZERO_LEN: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(ATTR_OTHER, 0, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 11, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        fit_len();
      end
      SH_ODD_PAD: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(ATTR_OTHER, 5, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        add_attr(sbrp_pkg::ATTR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        fit_len();
      end
      SH_TWO_ADDR: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(sbrp_pkg::ATTR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        fit_len();
      end
      SH_DECL_SHORT: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        set_len(8);
      end
      SH_DECL_LONG: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        set_len(300);
      end
      SH_CUT_VALUE: begin
        start_hdr(sbrp_pkg::TYPE_RESP, sbrp_pkg::COOKIE_VAL, $urandom, {$urandom, $urandom});
        add_attr(sbrp_pkg::ATTR_XOR_MAP, 8, sbrp_pkg::FAMILY_IPV4, $urandom, $urandom);
        fit_len();
        pkt.delete(pkt.size() - 1);
        pkt.delete(pkt.size() - 1);
      end
      default: pkt.delete();
    endcase
  endtask

  task automatic make_random_packet();
    int unsigned n_attr;
    int unsigned k;
    int unsigned len;
    int unsigned keep;
    logic [15:0] kind;
    logic [7:0]  fam;
    if ($urandom_range(99) < 12) begin
      pkt.delete();
      n_attr = $urandom_range(1, 40);
      for (k = 0; k < n_attr; k++) add_byte(8'($urandom));
      return;
    end
    start_hdr(($urandom_range(7) == 0) ? sbrp_pkg::TYPE_ERR : sbrp_pkg::TYPE_RESP,
              sbrp_pkg::COOKIE_VAL, edgy_word(), {edgy_word(), edgy_word()});
    n_attr = $urandom_range(4);
    for (k = 0; k < n_attr; k++) begin
      case ($urandom_range(5))
        0, 1: kind = sbrp_pkg::ATTR_XOR_MAP;
        2: kind = sbrp_pkg::ATTR_MAP;
        3: kind = ATTR_OTHER;
        default: kind = 16'($urandom);
      endcase
      if ($urandom_range(4) != 0) fam = sbrp_pkg::FAMILY_IPV4;
      else fam = ($urandom_range(1) == 1) ? FAMILY_IPV6 : 8'($urandom);
      case ($urandom_range(9))
        0: len = 20;
        1: len = $urandom_range(7);
        2: len = $urandom_range(9, 16);
        default: len = 8;
      endcase
      add_attr(kind, len, fam, 16'(edgy_word()), edgy_word());
    end
    fit_len();
    case ($urandom_range(11))
      0: set_len(pkt.size() - sbrp_pkg::HEADER_BYTES + $urandom_range(1, 64));
      1: if (pkt.size() > sbrp_pkg::HEADER_BYTES)
        set_len($urandom_range(pkt.size() - sbrp_pkg::HEADER_BYTES - 1));
      2: begin
        keep = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > keep) pkt.delete(pkt.size() - 1);
      end
      3: repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
      4: begin
        k = $urandom_range(7);
        pkt[k] = pkt[k] ^ (8'h01 << $urandom_range(7));
      end
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    bit     emitted;
    reply_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, last, emitted, r);
    if (emitted) replies_due.insert(replies_due.size(), use_typed ? typed_reply : r);
    bytes_sent++;
  endtask

  task automatic send_packet();
    int unsigned i;
    int unsigned n;
    n = pkt.size();
    for (i = 0; i < n; i++) send_byte(pkt[i], i == n - 1);
  endtask

  task automatic wait_replies_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  reply_t head_reply;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result item, status %0d", out_tuser);
        errors++;
      end else begin
        head_reply = replies_due.pop_front();
        check_field("status", head_reply.status, out_tuser);
        check_field("txn_id_high", head_reply.txn_hi, out_tdata[31:0]);
        check_field("txn_id_low", head_reply.txn_lo, out_tdata[95:32]);
        check_field("mapped_ipv4", head_reply.ipv4, out_tdata[127:96]);
        check_field("mapped_port", head_reply.port, out_tdata[143:128]);
        check_field("address_kind", head_reply.kind, out_tdata[145:144]);
      end
    end
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int packets;
    int start_bytes;
    clear_parse_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      build_shape(plan[i].shape);
      use_typed   = plan[i].typed;
      typed_reply = plan[i].want;
      send_packet();
    end
    use_typed = 1'b0;
    wait_replies_drained();

    packets     = 0;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES || packets < RANDOM_PACKETS) begin
      idle_pct = (packets >= 20 && packets < 32) ? 0 : IDLE_PERCENT;
      if (packets % 25 == 24) wait_replies_drained();
      make_random_packet();
      send_packet();
      packets++;
    end
    idle_pct = IDLE_PERCENT;

    wait_replies_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
